>>> src/mvcc_pkg.sv
package mvcc_pkg;

  localparam int unsigned TidSlots    = 8;
  localparam int unsigned RecordSlots = 64;
  localparam int unsigned LogDepth    = 16;
  localparam int unsigned KeyBits     = 64;

  localparam int unsigned TidIdxW = $clog2(TidSlots);
  localparam int unsigned RecIdxW = 6;
  localparam int unsigned RecCntW = 7;
  localparam int unsigned LogIdxW = $clog2(LogDepth);
  localparam int unsigned LogCntW = $clog2(LogDepth + 1);
  localparam int unsigned LogAddrW = TidIdxW + LogIdxW;

  typedef enum logic [2:0] {
    REQ_BEGIN    = 3'd0,
    REQ_ADD      = 3'd1,
    REQ_DELETE   = 3'd2,
    REQ_UPDATE   = 3'd3,
    REQ_COMMIT   = 3'd4,
    REQ_ROLLBACK = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_ACTIVE = 3'd1,
    ST_TID_FULL   = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_LOCKED     = 3'd4,
    ST_LOG_FULL   = 3'd5,
    ST_STORE_FULL = 3'd6,
    ST_NO_UNDO    = 3'd7
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // capture input word
    logic do_begin;    // grant id
    logic do_commit;   // free slot
    logic scan_start;  // record index <= 0
    logic scan_read;   // issue record read at scan index
    logic scan_next;   // advance scan index
    logic do_expire;   // expire record at scan index, log it
    logic do_add;      // append record, log it (key from sel_new)
    logic sel_new;     // use new key
    logic undo_start;  // undo pointer <= length
    logic undo_read;   // read log entry at pointer-1, pointer--
    logic undo_apply;  // apply fetched entry
    logic undo_free;   // free slot after rollback
    logic set_status;  // load status
    status_e status;
    logic keep_slot;   // keep slot on failure (partial update)
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_e   req;
    logic   bad_req;
    logic   active;      // txn_id active
    logic   tid_full;
    logic   log_full;
    logic   store_full;
    logic   log_empty;
    logic   scan_done;   // scan index reached record_total
    logic   rec_match;   // read record visible and key matches
    logic   rec_locked;  // matching record expirer is active
    logic   undo_done;   // undo pointer is zero
  } dp_stat_t;

endpackage

>>> src/mvcc_datapath.sv
module mvcc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvcc_pkg::dp_cmd_t   cmd_i,
  output mvcc_pkg::dp_stat_t  stat_o,
  input  logic [2:0]          req_type_i,
  input  logic [15:0]         txn_id_i,
  input  logic [63:0]         key_value_i,
  input  logic [63:0]         new_key_value_i,
  output logic                ok_o,
  output logic [2:0]          status_o,
  output logic [15:0]         granted_id_o,
  output logic [5:0]          record_slot_o
);
  import mvcc_pkg::*;

  // captured request
  logic [2:0]  req_q;
  logic [15:0] tid_q;
  logic [KeyBits-1:0] key_q, nkey_q;

  // transaction table
  logic [15:0]        act_q [TidSlots];
  logic [LogCntW-1:0] ulen_q [TidSlots];
  logic [TidIdxW:0]   act_total_q;
  logic [15:0]        next_id_q;

  // record store
  logic [KeyBits-1:0] rkey_mem [RecordSlots];
  logic [15:0]        rcre_mem [RecordSlots];
  logic [15:0]        rexp_mem [RecordSlots];
  logic [RecCntW-1:0] rtotal_q;

  // undo log
  logic [RecIdxW:0] log_mem [TidSlots*LogDepth];

  logic [RecCntW-1:0] scan_q;
  logic [LogCntW-1:0] uptr_q;
  logic [RecIdxW:0]   log_rd_q;
  logic [KeyBits-1:0] rd_key_q;
  logic [15:0]        rd_cre_q, rd_exp_q;

  logic [2:0]  st_q;
  logic [15:0] gid_q;
  logic [5:0]  slot_q;

  // slot lookup: lowest slot holding id
  function automatic logic [TidIdxW:0] find_slot(input logic [15:0] id,
                                                 input logic [15:0] tab [TidSlots]);
    logic [TidIdxW:0] r;
    r = {1'b1, {TidIdxW{1'b0}}};
    for (int i = TidSlots - 1; i >= 0; i--) begin
      if (id != 16'd0 && tab[i] == id) r = {1'b0, TidIdxW'(i)};
    end
    return r;
  endfunction

  logic [TidIdxW:0] sl_t, sl_c, sl_e;
  logic [TidIdxW-1:0] s_idx, free_idx;
  logic free_found;
  logic c_act, e_act, visible;

  assign sl_t  = find_slot(tid_q, act_q);
  assign sl_c  = find_slot(rd_cre_q, act_q);
  assign sl_e  = find_slot(rd_exp_q, act_q);
  assign s_idx = sl_t[TidIdxW-1:0];
  assign c_act = !sl_c[TidIdxW];
  assign e_act = !sl_e[TidIdxW];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TidSlots - 1; i >= 0; i--) begin
      if (act_q[i] == 16'd0) begin
        free_found = 1'b1;
        free_idx   = TidIdxW'(i);
      end
    end
  end

  always_comb begin
    visible = 1'b1;
    if (c_act && rd_cre_q != tid_q) visible = 1'b0;
    if (rd_exp_q != 16'd0 && (!e_act || rd_exp_q == tid_q)) visible = 1'b0;
  end

  assign stat_o.req        = req_e'(req_q);
  assign stat_o.bad_req    = (req_q > 3'd5);
  assign stat_o.active     = !sl_t[TidIdxW];
  assign stat_o.tid_full   = (act_total_q >= (TidIdxW+1)'(TidSlots)) || !free_found;
  assign stat_o.log_full   = (ulen_q[s_idx] >= LogCntW'(LogDepth));
  assign stat_o.store_full = (rtotal_q >= RecCntW'(RecordSlots));
  assign stat_o.log_empty  = (ulen_q[s_idx] == '0);
  assign stat_o.scan_done  = (scan_q >= rtotal_q) || (scan_q >= RecCntW'(RecordSlots));
  assign stat_o.rec_match  = visible && (rd_key_q == key_q);
  assign stat_o.rec_locked = (rd_exp_q != 16'd0) && e_act;
  assign stat_o.undo_done  = (uptr_q == '0);

  logic [LogAddrW-1:0] wr_log_addr, rd_log_addr;
  logic [LogIdxW-1:0] ulen_idx;
  assign ulen_idx    = ulen_q[s_idx][LogIdxW-1:0];
  assign wr_log_addr = {s_idx, ulen_idx};
  logic [LogCntW-1:0] uptr_m1;
  assign uptr_m1     = uptr_q - LogCntW'(1);
  assign rd_log_addr = {s_idx, uptr_m1[LogIdxW-1:0]};

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_type_i;
      tid_q  <= txn_id_i;
      key_q  <= key_value_i[KeyBits-1:0];
      nkey_q <= new_key_value_i[KeyBits-1:0];
    end
  end

  // record store and log memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      rkey_mem[rtotal_q[RecIdxW-1:0]] <= cmd_i.sel_new ? nkey_q : key_q;
      rcre_mem[rtotal_q[RecIdxW-1:0]] <= tid_q;
      rexp_mem[rtotal_q[RecIdxW-1:0]] <= 16'd0;
      log_mem[wr_log_addr] <= {1'b1, rtotal_q[RecIdxW-1:0]};
    end else if (cmd_i.do_expire) begin
      rexp_mem[scan_q[RecIdxW-1:0]] <= tid_q;
      log_mem[wr_log_addr] <= {1'b0, scan_q[RecIdxW-1:0]};
    end else if (cmd_i.undo_apply) begin
      rexp_mem[log_rd_q[RecIdxW-1:0]] <= log_rd_q[RecIdxW] ? tid_q : 16'd0;
    end
    if (cmd_i.scan_read) begin
      rd_key_q <= rkey_mem[scan_q[RecIdxW-1:0]];
      rd_cre_q <= rcre_mem[scan_q[RecIdxW-1:0]];
      rd_exp_q <= rexp_mem[scan_q[RecIdxW-1:0]];
    end
    if (cmd_i.undo_read) log_rd_q <= log_mem[rd_log_addr];
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TidSlots; i++) begin
        act_q[i]  <= 16'd0;
        ulen_q[i] <= '0;
      end
      act_total_q <= '0;
      next_id_q   <= 16'd1;
      rtotal_q    <= '0;
      scan_q      <= '0;
      uptr_q      <= '0;
      st_q        <= ST_OK;
      gid_q       <= 16'd0;
      slot_q      <= 6'd0;
    end else begin
      if (cmd_i.latch) begin
        gid_q  <= 16'd0;
        slot_q <= 6'd0;
      end
      if (cmd_i.do_begin) begin
        act_q[free_idx]  <= next_id_q;
        ulen_q[free_idx] <= '0;
        act_total_q      <= act_total_q + 1'b1;
        gid_q            <= next_id_q;
        next_id_q        <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
      end
      if (cmd_i.do_commit || cmd_i.undo_free) begin
        act_q[s_idx]  <= 16'd0;
        ulen_q[s_idx] <= '0;
        if (act_total_q != '0) act_total_q <= act_total_q - 1'b1;
      end
      if (cmd_i.scan_start) scan_q <= '0;
      else if (cmd_i.scan_next) scan_q <= scan_q + 1'b1;
      if (cmd_i.do_add) begin
        rtotal_q      <= rtotal_q + 1'b1;
        ulen_q[s_idx] <= ulen_q[s_idx] + 1'b1;
        slot_q        <= rtotal_q[RecIdxW-1:0];
      end else if (cmd_i.do_expire) begin
        ulen_q[s_idx] <= ulen_q[s_idx] + 1'b1;
        slot_q        <= scan_q[RecIdxW-1:0];
      end
      if (cmd_i.undo_start) uptr_q <= ulen_q[s_idx];
      else if (cmd_i.undo_read) uptr_q <= uptr_m1;
      if (cmd_i.set_status) begin
        st_q <= cmd_i.status;
        if (cmd_i.status != ST_OK && !cmd_i.keep_slot) slot_q <= 6'd0;
      end
    end
  end

  assign ok_o          = (st_q == ST_OK);
  assign status_o      = st_q;
  assign granted_id_o  = gid_q;
  assign record_slot_o = slot_q;

endmodule

>>> src/mvcc_ctrl.sv
module mvcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mvcc_pkg::dp_stat_t  stat_i,
  output mvcc_pkg::dp_cmd_t   cmd_o
);
  import mvcc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_SREAD  = 10'b0000000100,
    S_SCHECK = 10'b0000001000,
    S_ADD    = 10'b0000010000,
    S_UREAD  = 10'b0000100000,
    S_UAPPLY = 10'b0001000000,
    S_DONE   = 10'b0010000000,
    S_OUT    = 10'b0100000000,
    S_ULOOP  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_status = 1'b1;
        state_d = S_OUT;
        if (stat_i.bad_req) begin
          cmd_o.status = ST_NOT_ACTIVE;
        end else if (stat_i.req == REQ_BEGIN) begin
          if (stat_i.tid_full) cmd_o.status = ST_TID_FULL;
          else cmd_o.do_begin = 1'b1;
        end else if (!stat_i.active) begin
          cmd_o.status = ST_NOT_ACTIVE;
        end else begin
          unique case (stat_i.req)
            REQ_ADD: begin
              if (stat_i.log_full) cmd_o.status = ST_LOG_FULL;
              else if (stat_i.store_full) cmd_o.status = ST_STORE_FULL;
              else cmd_o.do_add = 1'b1;
            end
            REQ_DELETE, REQ_UPDATE: begin
              cmd_o.set_status = 1'b0;
              cmd_o.scan_start = 1'b1;
              state_d = S_SREAD;
            end
            REQ_COMMIT: cmd_o.do_commit = 1'b1;
            default: begin
              if (stat_i.log_empty) cmd_o.status = ST_NO_UNDO;
              else begin
                cmd_o.set_status = 1'b0;
                cmd_o.undo_start = 1'b1;
                state_d = S_UREAD;
              end
            end
          endcase
        end
      end
      S_SREAD: begin
        if (stat_i.scan_done) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = ST_NOT_FOUND;
          state_d = S_OUT;
        end else begin
          cmd_o.scan_read = 1'b1;
          state_d = S_SCHECK;
        end
      end
      S_SCHECK: begin
        if (!stat_i.rec_match) begin
          cmd_o.scan_next = 1'b1;
          state_d = S_SREAD;
        end else begin
          cmd_o.set_status = 1'b1;
          state_d = S_OUT;
          if (stat_i.rec_locked) cmd_o.status = ST_LOCKED;
          else if (stat_i.log_full) cmd_o.status = ST_LOG_FULL;
          else begin
            cmd_o.do_expire = 1'b1;
            if (stat_i.req == REQ_UPDATE) begin
              cmd_o.set_status = 1'b0;
              state_d = S_ADD;
            end
          end
        end
      end
      S_ADD: begin
        cmd_o.set_status = 1'b1;
        cmd_o.keep_slot  = 1'b1;
        cmd_o.sel_new    = 1'b1;
        if (stat_i.log_full) cmd_o.status = ST_LOG_FULL;
        else if (stat_i.store_full) cmd_o.status = ST_STORE_FULL;
        else cmd_o.do_add = 1'b1;
        state_d = S_OUT;
      end
      S_UREAD: begin
        if (stat_i.undo_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.undo_read = 1'b1;
          state_d = S_UAPPLY;
        end
      end
      S_UAPPLY: begin
        cmd_o.undo_apply = 1'b1;
        state_d = S_ULOOP;
      end
      S_ULOOP: state_d = S_UREAD;
      S_DONE: begin
        cmd_o.undo_free  = 1'b1;
        cmd_o.set_status = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("accept while result pending");
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.do_add && cmd_o.do_expire))
    else $error("two store writes");
`endif

endmodule

>>> src/mvcc_transaction_record_store_unit.sv
// Sequence, word taken to result: begin/add/commit go through decode to the result;
// delete/update scan the stored records, reading and checking one at a time, and update
// then appends the new record; rollback reads and applies each undo entry, last first.
// Throughput: one request at a time; the next word is taken the cycle after the result.
// Reset: rst_ni asynchronous active low clears the id table, counters and undo lengths;
// record and log memories are not cleared and are only read after being written.
module mvcc_transaction_record_store_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,  // req_type[2:0], txn_id[18:3], key_value[82:19],
                                      // new_key_value[146:83], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata   // ok[0], status[3:1], granted_id[19:4],
                                      // record_slot[25:20], zero pad
);
  import mvcc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic       ok;
  logic [2:0] status;
  logic [15:0] gid;
  logic [5:0]  slot;

  mvcc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mvcc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (s_axis_tdata[2:0]),
    .txn_id_i       (s_axis_tdata[18:3]),
    .key_value_i    (s_axis_tdata[82:19]),
    .new_key_value_i(s_axis_tdata[146:83]),
    .ok_o           (ok),
    .status_o       (status),
    .granted_id_o   (gid),
    .record_slot_o  (slot)
  );

  assign m_axis_tdata = {6'd0, slot, gid, status, ok};

endmodule
